>>> hdl/hsbp_pkg.sv
// Shared constants and types for the Huffman symbol bit packer.
`timescale 1ns / 1ps

package hsbp_pkg;

  // Fixed field widths
  localparam int KIND_W     = 2;
  localparam int SYM_W      = 8;
  localparam int CODE_W     = 32;
  localparam int CODE_LEN_W = 6;
  localparam int BYTE_W     = 8;
  localparam int PEND_W     = BYTE_W - 1;

  // Parameter defaults
  localparam int MAX_CODE_LEN_DEF  = 32;
  localparam int ALPHABET_SIZE_DEF = 256;

  // Input item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_FLUSH  = 2'd2
  } kind_t;

  // Request from the lookup stage to the pack stage
  typedef struct packed {
    logic vld;
    logic flush;
  } pk_req_t;

endpackage

>>> hdl/hsbp_code_table.sv
// Codeword table: one-port-write, one-port-read memory with per-entry valid bits.
`timescale 1ns / 1ps

module hsbp_code_table #(
  parameter int CODE_LEN_MAX  = hsbp_pkg::MAX_CODE_LEN_DEF,
  parameter int ALPHABET_SIZE = hsbp_pkg::ALPHABET_SIZE_DEF,
  localparam int LW = $clog2(CODE_LEN_MAX + 1),
  localparam int AW = $clog2(ALPHABET_SIZE)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic [CODE_LEN_MAX-1:0] wr_bits,
  input  logic [LW-1:0]           wr_len,
  input  logic                    rd_en,
  input  logic [AW-1:0]           rd_addr,
  output logic [CODE_LEN_MAX-1:0] rd_bits,
  output logic [LW-1:0]           rd_len
);

  import hsbp_pkg::*;

  localparam int EW = LW + CODE_LEN_MAX;

  logic [EW-1:0]            mem [ALPHABET_SIZE];
  logic [EW-1:0]            rd_data_r;
  logic [ALPHABET_SIZE-1:0] vld_r;
  logic                     rd_vld_r;

  // Write and read the entry storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_len, wr_bits};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Track which entries were loaded since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // An entry never loaded reads as an empty codeword
  assign rd_len  = rd_vld_r ? rd_data_r[EW-1:CODE_LEN_MAX] : '0;
  assign rd_bits = rd_vld_r ? rd_data_r[CODE_LEN_MAX-1:0] : '0;

endmodule

>>> hdl/hsbp_packer.sv
// Pack stage: merges codewords into the bit accumulator and emits one byte per cycle while the output is not stalled.
`timescale 1ns / 1ps

module hsbp_packer #(
  parameter int CODE_LEN_MAX = hsbp_pkg::MAX_CODE_LEN_DEF,
  localparam int LW = $clog2(CODE_LEN_MAX + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hsbp_pkg::pk_req_t           req,
  input  logic [LW-1:0]               code_len,
  input  logic [CODE_LEN_MAX-1:0]     code_bits,
  output logic                        take,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [hsbp_pkg::BYTE_W-1:0] out_byte,
  output logic                        out_last
);

  import hsbp_pkg::*;

  localparam int ACC_W = CODE_LEN_MAX + PEND_W;
  localparam int CW    = $clog2(ACC_W + 1);
  localparam int SW    = $clog2(BYTE_W + 1);

  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;

  logic              out_free;
  logic              emit;
  logic [CW-1:0]     emit_sh;
  logic [CW-1:0]     rem_cnt;
  logic [SW-1:0]     rem_sh;
  logic [PEND_W-1:0] pend;
  logic [BYTE_W-1:0] flush_byte;

  // Emit the oldest full byte when the output register has room
  assign out_free = !out_valid_r || !out_stall;
  assign emit     = (cnt_r >= CW'(BYTE_W)) && out_free;
  assign emit_sh  = cnt_r - CW'(BYTE_W);
  assign rem_cnt  = emit ? emit_sh : cnt_r;

  // Absorb a new item once fewer than a byte of bits remain
  assign take   = req.vld && (rem_cnt < CW'(BYTE_W));
  assign rem_sh = SW'(rem_cnt);
  assign pend   = acc_r[PEND_W-1:0] & ~({PEND_W{1'b1}} << rem_sh);

  // Pad the pending bits with zeros at the low end
  assign flush_byte = {1'b0, pend} << (SW'(BYTE_W) - rem_sh);

  always_comb begin
    acc_nxt = acc_r;
    cnt_nxt = rem_cnt;
    if (take) begin
      if (req.flush) begin
        acc_nxt = ACC_W'(flush_byte);
        cnt_nxt = (rem_cnt != '0) ? CW'(BYTE_W) : '0;
      end else begin
        acc_nxt = ({{(ACC_W-PEND_W){1'b0}}, pend} << code_len)
                | {{PEND_W{1'b0}}, code_bits};
        cnt_nxt = rem_cnt + CW'(code_len);
      end
    end
  end

  // Load or drain the output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = BYTE_W'(acc_r >> emit_sh);
      out_last_nxt  = emit_sh < CW'(BYTE_W);
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    acc_r      <= acc_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

>>> hdl/huffman_symbol_bit_packer.sv
// Top level of the Huffman symbol bit packer: table lookup stage and pack stage.
`timescale 1ns / 1ps
//
//  channel | ports                                              | direction
//  --------+----------------------------------------------------+----------
//  input   | in_valid, in_stall, in_kind, in_symbol,            | in
//          | in_code_bits, in_code_length                       |
//  result  | out_valid, out_stall, out_byte, out_last_of_run    | out
//
//  Loads are written to the code table on transfer. Encode and flush items pass
//  a registered table lookup, then the pack stage's accumulator and output
//  register. The pack stage emits one byte per cycle while out_stall is low and
//  takes a new item only once fewer than eight bits remain; an item yields up to
//  4 bytes for an encode and at most 1 for a flush.
//  Reset clears the table valid bits at once; no clearing pass is needed.
//  A stalled output byte holds; the input stalls while the lookup stage waits.

module huffman_symbol_bit_packer #(
  parameter int MAX_CODE_LEN  = hsbp_pkg::MAX_CODE_LEN_DEF,
  parameter int ALPHABET_SIZE = hsbp_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [hsbp_pkg::KIND_W-1:0]     in_kind,
  input  logic [hsbp_pkg::SYM_W-1:0]      in_symbol,
  input  logic [hsbp_pkg::CODE_W-1:0]     in_code_bits,
  input  logic [hsbp_pkg::CODE_LEN_W-1:0] in_code_length,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [hsbp_pkg::BYTE_W-1:0]     out_byte,
  output logic                            out_last_of_run
);

  import hsbp_pkg::*;

  localparam int LEN_LIM = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int LW      = $clog2(LEN_LIM + 1);
  localparam int AW      = $clog2(ALPHABET_SIZE);

  logic               in_xfer;
  logic               sym_ok;
  logic               is_load, is_encode, is_flush;
  logic [LW-1:0]      len_clamp;
  logic [LEN_LIM-1:0] bits_masked;

  logic               s1_valid_r, s1_valid_nxt;
  logic               s1_flush_r, s1_flush_nxt;
  logic               s1_hit_r, s1_hit_nxt;

  logic [LEN_LIM-1:0] rd_bits;
  logic [LW-1:0]      rd_len;
  pk_req_t            pk_req;
  logic [LEN_LIM-1:0] pk_bits;
  logic [LW-1:0]      pk_len;
  logic               pk_take;

  // Decode the input item
  assign in_xfer   = in_valid && !in_stall;
  assign sym_ok    = {1'b0, in_symbol} < (SYM_W + 1)'(ALPHABET_SIZE);
  assign is_load   = in_kind == KIND_LOAD;
  assign is_encode = in_kind == KIND_ENCODE;
  assign is_flush  = in_kind == KIND_FLUSH;

  // Saturate the code length and drop codeword bits above it
  assign len_clamp   = (in_code_length > CODE_LEN_W'(LEN_LIM)) ? LW'(LEN_LIM)
                                                                : LW'(in_code_length);
  assign bits_masked = in_code_bits[LEN_LIM-1:0] & ~({LEN_LIM{1'b1}} << len_clamp);

  hsbp_code_table #(
    .CODE_LEN_MAX  (LEN_LIM),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_code_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_xfer && is_load && sym_ok),
    .wr_addr (in_symbol[AW-1:0]),
    .wr_bits (bits_masked),
    .wr_len  (len_clamp),
    .rd_en   (in_xfer && is_encode),
    .rd_addr (in_symbol[AW-1:0]),
    .rd_bits (rd_bits),
    .rd_len  (rd_len)
  );

  // Hold the lookup stage until the pack stage takes it
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_flush_nxt = s1_flush_r;
    s1_hit_nxt   = s1_hit_r;
    if (pk_take) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_xfer) begin
      s1_valid_nxt = is_encode || is_flush;
      s1_flush_nxt = is_flush;
      s1_hit_nxt   = sym_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    s1_flush_r <= s1_flush_nxt;
    s1_hit_r   <= s1_hit_nxt;
  end

  assign in_stall = s1_valid_r && !pk_take;

  // Symbols outside the alphabet encode as nothing
  assign pk_req.vld   = s1_valid_r;
  assign pk_req.flush = s1_flush_r;
  assign pk_len       = s1_hit_r ? rd_len : '0;
  assign pk_bits      = s1_hit_r ? rd_bits : '0;

  hsbp_packer #(
    .CODE_LEN_MAX (LEN_LIM)
  ) u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (pk_req),
    .code_len  (pk_len),
    .code_bits (pk_bits),
    .take      (pk_take),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .out_last  (out_last_of_run)
  );

`ifndef NO_ASSERTIONS
  // A stalled byte that is not the last of its item leaves a full byte behind it
  a_no_take_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_of_run && out_stall) |-> !pk_take)
    else $error("pack stage absorbed an item in the middle of a byte run");

  // Reset empties the result channel
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The pack stage only takes a request that is present
  a_take_needs_req: assert property (@(posedge clk) disable iff (!rst_n)
    pk_take |-> s1_valid_r)
    else $error("pack stage took an empty lookup stage");
`endif

endmodule

>>> bench/huffman_symbol_bit_packer_tb.sv
// Self-checking testbench for the Huffman symbol bit packer: queued driver, monitor and byte predictor.
`timescale 1ns / 1ps

module huffman_symbol_bit_packer_tb;
  import hsbp_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int LEN_CAP      = (MAX_CODE_LEN_DEF < CODE_W) ? MAX_CODE_LEN_DEF : CODE_W;
  localparam int RANDOM_ITEMS = 260;
  localparam int LONG_HOLD    = 300;
  localparam int QUIET_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 20;

  typedef struct {
    logic [KIND_W-1:0]     kind;
    logic [SYM_W-1:0]      symbol;
    logic [CODE_W-1:0]     bits;
    logic [CODE_LEN_W-1:0] len;
    int unsigned           gap;
    bit                    drain;
  } pack_item_t;

  typedef struct {
    logic [BYTE_W-1:0] value;
    logic              last;
  } packed_byte_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [KIND_W-1:0]     in_kind = '0;
  logic [SYM_W-1:0]      in_symbol = '0;
  logic [CODE_W-1:0]     in_code_bits = '0;
  logic [CODE_LEN_W-1:0] in_code_length = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [BYTE_W-1:0]     out_byte;
  logic                  out_last_of_run;

  // Stimulus and expectation stores
  pack_item_t   pending_items[$];
  packed_byte_t expected_bytes[$];

  // Shadow copy of the packer state
  logic [CODE_W-1:0] code_word [ALPHABET_SIZE_DEF];
  int unsigned       code_len  [ALPHABET_SIZE_DEF];
  logic [PEND_W-1:0] pend_bits;
  int unsigned       pend_cnt;

  // Driver state
  pack_item_t  cur_item;
  pack_item_t  next_item;
  bit          have_next;
  int unsigned gap_left;
  bit          took;
  bit          show;

  // Monitor state
  int unsigned hold_left;
  bit          long_hold_done;

  int unsigned errors;
  int unsigned bytes_checked;
  int unsigned quiet_cycles;
  int unsigned n_load, n_encode, n_flush, n_ignored;

  logic [SYM_W-1:0] pool [16];
  int unsigned      counted;
  int unsigned      pick;
  int unsigned      r;
  int unsigned      idx;

  huffman_symbol_bit_packer DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_symbol       (in_symbol),
    .in_code_bits    (in_code_bits),
    .in_code_length  (in_code_length),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  // Queue one item; the sender gap runs in phases, with one gap-free phase in four
  task automatic add_item(input logic [KIND_W-1:0] kind, input logic [SYM_W-1:0] sym,
                          input logic [CODE_W-1:0] bits, input logic [CODE_LEN_W-1:0] len,
                          input bit drain);
    pack_item_t it;
    it.kind   = kind;
    it.symbol = sym;
    it.bits   = bits;
    it.len    = len;
    it.drain  = drain;
    it.gap    = (((pending_items.size() / 48) % 4) == 2) ? 0 : $urandom_range(0, 11);
    pending_items.push_back(it);
  endtask

  // Apply one transfer to the shadow state and queue the bytes it yields
  function automatic void pack_expected_bytes(input pack_item_t it);
    int unsigned  len;
    int unsigned  total;
    logic [63:0]  acc;
    logic [63:0]  mask;
    logic [63:0]  sh;
    logic [15:0]  fl;
    packed_byte_t e;
    case (it.kind)
      KIND_LOAD: begin
        n_load++;
        code_word[it.symbol] = it.bits;
        code_len[it.symbol]  = (it.len > LEN_CAP) ? LEN_CAP : it.len;
      end
      KIND_ENCODE: begin
        n_encode++;
        len = code_len[it.symbol];
        if (len != 0) begin
          mask  = (64'd1 << len) - 64'd1;
          acc   = ({57'd0, pend_bits} << len) | ({32'd0, code_word[it.symbol]} & mask);
          total = pend_cnt + len;
          // Emit every full byte, MSB first
          while (total >= 8) begin
            total   = total - 8;
            sh      = acc >> total;
            e.value = sh[7:0];
            e.last  = (total < 8);
            expected_bytes.push_back(e);
          end
          sh        = acc & ((64'd1 << total) - 64'd1);
          pend_bits = sh[PEND_W-1:0];
          pend_cnt  = total;
        end
      end
      KIND_FLUSH: begin
        n_flush++;
        if (pend_cnt != 0) begin
          fl        = {9'd0, pend_bits} << (8 - pend_cnt);
          e.value   = fl[7:0];
          e.last    = 1'b1;
          expected_bytes.push_back(e);
          pend_bits = '0;
          pend_cnt  = 0;
        end
      end
      default: begin
        n_ignored++;
      end
    endcase
  endfunction

  // Compare one output transfer with the oldest expectation
  task automatic check_byte();
    packed_byte_t e;
    if (expected_bytes.size() == 0) begin
      report_mismatch($sformatf("unexpected byte %02h last %0b", out_byte, out_last_of_run));
    end else begin
      e = expected_bytes.pop_front();
      if (out_byte !== e.value)
        report_mismatch($sformatf("byte %0d: got %02h, want %02h",
                                  bytes_checked, out_byte, e.value));
      if (out_last_of_run !== e.last)
        report_mismatch($sformatf("byte %0d: last_of_run got %0b, want %0b",
                                  bytes_checked, out_last_of_run, e.last));
    end
  endtask

  // Driver: hold the offer until transfer, then wait out the next gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      have_next = 1'b0;
      gap_left  = 0;
      pend_bits = '0;
      pend_cnt  = 0;
      for (int i = 0; i < ALPHABET_SIZE_DEF; i++) begin
        code_word[i] = '0;
        code_len[i]  = 0;
      end
    end else begin
      took = in_valid && !in_stall;
      if (took)
        pack_expected_bytes(cur_item);
      show = in_valid && !took;
      if (!show) begin
        if (!have_next && pending_items.size() != 0) begin
          next_item = pending_items.pop_front();
          have_next = 1'b1;
          gap_left  = next_item.gap;
        end
        // A drain item waits until every expected byte is out
        if (have_next && !(next_item.drain && expected_bytes.size() != 0)) begin
          if (gap_left != 0) begin
            gap_left--;
          end else begin
            cur_item       = next_item;
            have_next      = 1'b0;
            show           = 1'b1;
            in_kind        <= next_item.kind;
            in_symbol      <= next_item.symbol;
            in_code_bits   <= next_item.bits;
            in_code_length <= next_item.len;
          end
        end
      end
      in_valid <= show;
    end
  end

  // Monitor: check each transfer, then draw the stall before the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall      <= 1'b0;
      hold_left      = 0;
      long_hold_done = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_byte();
        bytes_checked++;
        if (!long_hold_done && bytes_checked == 40) begin
          hold_left      = LONG_HOLD;
          long_hold_done = 1'b1;
        end else if (((bytes_checked / 32) % 3) == 1) begin
          hold_left = 0;
        end else begin
          hold_left = $urandom_range(0, 11);
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TIMEOUT: no transfer for %0d cycles, %0d bytes still expected",
               quiet_cycles, expected_bytes.size());
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // Directed: unloaded symbol, empty flush, extreme codewords and lengths
    add_item(KIND_ENCODE, 8'h05, 32'h0, 6'd0, 1'b0);
    add_item(KIND_FLUSH, 8'h00, 32'h0, 6'd0, 1'b0);
    add_item(KIND_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32, 1'b0);
    add_item(KIND_LOAD, 8'hFF, 32'hA5A5_A5A5, 6'd40, 1'b0);
    add_item(KIND_LOAD, 8'h01, 32'hFFFF_FF05, 6'd3, 1'b0);
    add_item(KIND_LOAD, 8'h80, 32'h0000_0000, 6'd63, 1'b0);
    add_item(KIND_LOAD, 8'h02, 32'h0000_0001, 6'd1, 1'b0);
    add_item(KIND_LOAD, 8'h03, 32'h0000_007F, 6'd7, 1'b0);
    add_item(KIND_UNUSED, 8'h3C, 32'h1234_5678, 6'd17, 1'b0);
    add_item(KIND_ENCODE, 8'h00, 32'h0, 6'd0, 1'b0);
    add_item(KIND_ENCODE, 8'h01, 32'h0, 6'd0, 1'b0);
    add_item(KIND_ENCODE, 8'hFF, 32'h0, 6'd0, 1'b0);
    add_item(KIND_ENCODE, 8'h03, 32'h0, 6'd0, 1'b0);
    add_item(KIND_FLUSH, 8'h00, 32'h0, 6'd0, 1'b0);
    add_item(KIND_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b0);
    // Build up seven pending bits, then a 32-bit code for the four-byte worst case
    add_item(KIND_ENCODE, 8'h01, 32'h0, 6'd0, 1'b0);
    add_item(KIND_ENCODE, 8'h02, 32'h0, 6'd0, 1'b0);
    add_item(KIND_ENCODE, 8'h02, 32'h0, 6'd0, 1'b0);
    add_item(KIND_ENCODE, 8'h02, 32'h0, 6'd0, 1'b0);
    add_item(KIND_ENCODE, 8'h02, 32'h0, 6'd0, 1'b0);
    add_item(KIND_ENCODE, 8'h80, 32'h0, 6'd0, 1'b0);
    add_item(KIND_FLUSH, 8'h00, 32'h0, 6'd0, 1'b0);
    // Zero length unloads a symbol
    add_item(KIND_LOAD, 8'h01, 32'hFFFF_FFFF, 6'd0, 1'b0);
    add_item(KIND_ENCODE, 8'h01, 32'h0, 6'd0, 1'b0);
    add_item(KIND_ENCODE, 8'h03, 32'h0, 6'd0, 1'b0);
    add_item(KIND_FLUSH, 8'h00, 32'h0, 6'd0, 1'b0);

    // Random: load a symbol pool, then mostly encodes from it
    for (int i = 0; i < 16; i++) begin
      pool[i] = SYM_W'($urandom_range(0, 255));
      add_item(KIND_LOAD, pool[i], $urandom, CODE_LEN_W'($urandom_range(1, 32)), (i == 0));
    end
    counted = 16;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        add_item(KIND_UNUSED, SYM_W'($urandom_range(0, 255)), $urandom,
                 CODE_LEN_W'($urandom_range(0, 63)), 1'b0);
      end else begin
        counted++;
        idx = $urandom_range(0, 15);
        if (pick < 13) begin
          r = $urandom_range(0, 9);
          if ($urandom_range(0, 4) == 0)
            add_item(KIND_LOAD, SYM_W'($urandom_range(0, 255)), $urandom,
                     CODE_LEN_W'($urandom_range(0, 63)), 1'b0);
          else if (r < 8)
            add_item(KIND_LOAD, pool[idx], $urandom, CODE_LEN_W'($urandom_range(1, 32)),
                     1'b0);
          else if (r == 8)
            add_item(KIND_LOAD, pool[idx], $urandom, CODE_LEN_W'($urandom_range(33, 63)),
                     1'b0);
          else
            add_item(KIND_LOAD, pool[idx], $urandom, 6'd0, 1'b0);
        end else if (pick < 83) begin
          add_item(KIND_ENCODE,
                   ($urandom_range(0, 9) == 0) ? SYM_W'($urandom_range(0, 255)) : pool[idx],
                   $urandom, CODE_LEN_W'($urandom_range(0, 63)),
                   (counted == RANDOM_ITEMS / 2));
        end else begin
          add_item(KIND_FLUSH, SYM_W'($urandom_range(0, 255)), $urandom,
                   CODE_LEN_W'($urandom_range(0, 63)), (counted == RANDOM_ITEMS / 2));
        end
      end
    end
    add_item(KIND_FLUSH, 8'h00, 32'h0, 6'd0, 1'b0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Drain stimulus, then expectations, then a short tail for stray bytes
    while (pending_items.size() != 0 || have_next || in_valid)
      @(posedge clk);
    while (expected_bytes.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d loads, %0d encodes, %0d flushes, %0d unused-kind items",
             n_load, n_encode, n_flush, n_ignored);
    $display("%0d output bytes checked, %0d mismatches", bytes_checked, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
